>>> sv/acv_pkg.sv
// package: aes tables, round functions and shared types for the challenge verifier
`default_nettype none
package acv_pkg;

    localparam int BLK_W    = 128;
    localparam int HALF_W   = 64;
    localparam int NUM_RND  = 10;
    localparam int RK_CNT   = NUM_RND + 1;
    localparam int Q_DEPTH  = 4;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] KEY_HIGH_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_LOW_IDX  = 2'd1;

    // one accepted transaction: encrypted response, peer challenge, expected challenge
    typedef struct packed {
        logic [BLK_W-1:0] resp;
        logic [BLK_W-1:0] chal;
        logic [BLK_W-1:0] expect_blk;
    } item_t;

    // queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef logic [RK_CNT-1:0][BLK_W-1:0] rk_set_t;

    // forward s-box, entry 0 in the top byte
    localparam logic [2047:0] SBOX_V = {
        256'h637c777bf26b6fc53001672bfed7ab76_ca82c97dfa5947f0add4a2af9ca472c0,
        256'hb7fd9326363ff7cc34a5e5f171d83115_04c723c31896059a071280e2eb27b275,
        256'h09832c1a1b6e5aa0523bd6b329e32f84_53d100ed20fcb15b6acbbe394a4c58cf,
        256'hd0efaafb434d338545f9027f503c9fa8_51a3408f929d38f5bcb6da2110fff3d2,
        256'hcd0c13ec5f974417c4a77e3d645d1973_60814fdc222a908846eeb814de5e0bdb,
        256'he0323a0a4906245cc2d3ac629195e479_e7c8376d8dd54ea96c56f4ea657aae08,
        256'hba78252e1ca6b4c6e8dd741f4bbd8b8a_703eb5664803f60e613557b986c11d9e,
        256'he1f8981169d98e949b1e87e9ce5528df_8ca1890dbfe6426841992d0fb054bb16
    };

    // inverse s-box, entry 0 in the top byte
    localparam logic [2047:0] INV_SBOX_V = {
        256'h52096ad53036a538bf40a39e81f3d7fb_7ce339829b2fff87348e4344c4dee9cb,
        256'h547b9432a6c2233dee4c950b42fac34e_082ea16628d924b2765ba2496d8bd125,
        256'h72f8f66486689816d4a45ccc5d65b692_6c704850fdedb9da5e154657a78d9d84,
        256'h90d8ab008cbcd30af7e45805b8b34506_d02c1e8fca3f0f02c1afbd0301138a6b,
        256'h3a9111414f67dcea97f2cfcef0b4e673_96ac7422e7ad3585e2f937e81c75df6e,
        256'h47f11a711d29c5896fb7620eaa18be1b_fc563e4bc6d279209adbc0fe78cd5af4,
        256'h1fdda8338807c731b11210592780ec5f_60517fa919b54a0d2de57a9f93c99cef,
        256'ha0e03b4dae2af5b0c8ebbb3c83539961_172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_V[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        return INV_SBOX_V[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // round constant for key expansion steps one to ten
    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] rc;
        case (n)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // next round key from the previous one
    function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
                                                  input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tw, n0, n1, n2, n3;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        n0 = w0 ^ tw;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // one encryption round: sub bytes, shift rows, mix columns unless last, add key
    function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic last);
        logic [15:0][7:0] a, t, m;
        logic [7:0] a0, a1, a2, a3;
        a = s;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[15 - (r + 4 * c)] = sbox(a[15 - (r + 4 * ((c + r) % 4))]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[15 - 4 * c];
            a1 = t[14 - 4 * c];
            a2 = t[13 - 4 * c];
            a3 = t[12 - 4 * c];
            m[15 - 4 * c] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[14 - 4 * c] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[13 - 4 * c] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[12 - 4 * c] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return (last ? t : m) ^ rk;
    endfunction

    // one decryption round: inv shift rows, inv sub bytes, add key, inv mix unless last
    function automatic logic [BLK_W-1:0] dec_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic last);
        logic [15:0][7:0] a, t, m;
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        a = s;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[15 - (r + 4 * c)] = inv_sbox(a[15 - (r + 4 * ((c + 4 - r) % 4))]);
            end
        end
        t = t ^ rk;
        for (int c = 0; c < 4; c++) begin
            a0 = t[15 - 4 * c];
            a1 = t[14 - 4 * c];
            a2 = t[13 - 4 * c];
            a3 = t[12 - 4 * c];
            x0 = xt(a0); y0 = xt(x0); z0 = xt(y0);
            x1 = xt(a1); y1 = xt(x1); z1 = xt(y1);
            x2 = xt(a2); y2 = xt(x2); z2 = xt(y2);
            x3 = xt(a3); y3 = xt(x3); z3 = xt(y3);
            // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
            m[15 - 4 * c] = (z0 ^ y0 ^ x0) ^ (z1 ^ x1 ^ a1) ^ (z2 ^ y2 ^ a2) ^ (z3 ^ a3);
            m[14 - 4 * c] = (z0 ^ a0) ^ (z1 ^ y1 ^ x1) ^ (z2 ^ x2 ^ a2) ^ (z3 ^ y3 ^ a3);
            m[13 - 4 * c] = (z0 ^ y0 ^ a0) ^ (z1 ^ a1) ^ (z2 ^ y2 ^ x2) ^ (z3 ^ x3 ^ a3);
            m[12 - 4 * c] = (z0 ^ x0 ^ a0) ^ (z1 ^ y1 ^ a1) ^ (z2 ^ a2) ^ (z3 ^ y3 ^ x3);
        end
        return last ? t : m;
    endfunction

endpackage
`default_nettype wire

>>> sv/acv_key_sched.sv
// key registers and round key expansion, one round key per cycle
`default_nettype none
module acv_key_sched (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [acv_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [acv_pkg::HALF_W-1:0]     cfg_wdata,
    output logic                                busy,
    output acv_pkg::rk_set_t                    round_keys
);
    import acv_pkg::*;

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic              busy_reg;
    logic [3:0]        cnt_reg;
    logic [BLK_W-1:0]  cur_reg;
    logic [BLK_W-1:0]  rk_reg [RK_CNT];
    logic [BLK_W-1:0]  step_next;

    // register writes and expansion control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b1;
            cnt_reg      <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == KEY_HIGH_IDX) begin
                key_high_reg <= cfg_wdata;
            end
            if (cfg_addr == KEY_LOW_IDX) begin
                key_low_reg <= cfg_wdata;
            end
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(NUM_RND)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign step_next = key_step(cur_reg, rcon(cnt_reg));

    // round key store
    always_ff @(posedge aclk) begin
        if (busy_reg && !cfg_wr_en) begin
            if (cnt_reg == 4'd0) begin
                rk_reg[0] <= {key_high_reg, key_low_reg};
                cur_reg   <= {key_high_reg, key_low_reg};
            end else begin
                rk_reg[cnt_reg] <= step_next;
                cur_reg         <= step_next;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < RK_CNT; i++) begin
            round_keys[i] = rk_reg[i];
        end
    end

    assign busy = busy_reg;

    // expansion finishes only after the last round key
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !cfg_wr_en && cnt_reg != 4'(NUM_RND) |=> busy_reg)
        else $error("key expansion ended early");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> busy_reg && cnt_reg == 4'd0)
        else $error("key write did not restart expansion");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= 4'(NUM_RND))
        else $error("expansion counter out of range");

endmodule
`default_nettype wire

>>> sv/acv_queue.sv
// short queue between the accepting front and the round pipeline
`default_nettype none
module acv_queue #(
    parameter int DEPTH = acv_pkg::Q_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire acv_pkg::item_t  push_item,
    input  wire logic            pop,
    output acv_pkg::item_t       head_item,
    output acv_pkg::q_stat_t     stat
);
    import acv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // pointer and fill tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

    assert property (@(posedge aclk) disable iff (!aresetn) !(push && stat.full))
        else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && stat.empty))
        else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule
`default_nettype wire

>>> sv/acv_round_pipe.sv
// back end: ten decrypt and ten encrypt rounds side by side, compare, output register
`default_nettype none
module acv_round_pipe (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire acv_pkg::q_stat_t    q_stat,
    input  wire acv_pkg::item_t      head_item,
    input  wire acv_pkg::rk_set_t    round_keys,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     out_ok,
    output logic [acv_pkg::BLK_W-1:0] out_reply
);
    import acv_pkg::*;

    logic             adv;
    logic             vld_reg [RK_CNT];
    logic [BLK_W-1:0] enc_reg [RK_CNT];
    logic [BLK_W-1:0] dec_reg [RK_CNT];
    logic [BLK_W-1:0] exp_reg [RK_CNT];
    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [BLK_W-1:0] out_reply_reg;

    // whole pipeline moves whenever the output slot frees
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !q_stat.empty;

    // initial key whitening
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            enc_reg[0] <= head_item.chal ^ round_keys[0];
            dec_reg[0] <= head_item.resp ^ round_keys[NUM_RND];
            exp_reg[0] <= head_item.expect_blk;
        end
    end

    // one round per stage
    for (genvar k = 1; k < RK_CNT; k++) begin : g_rnd
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                enc_reg[k] <= enc_round(enc_reg[k-1], round_keys[k], k == NUM_RND);
                dec_reg[k] <= dec_round(dec_reg[k-1], round_keys[NUM_RND-k], k == NUM_RND);
                exp_reg[k] <= exp_reg[k-1];
            end
        end
    end

    // compare and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[NUM_RND];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_ok_reg    <= (dec_reg[NUM_RND] == exp_reg[NUM_RND]);
            out_reply_reg <= (dec_reg[NUM_RND] == exp_reg[NUM_RND]) ? enc_reg[NUM_RND] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_reply = out_reply_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reply_reg))
        else $error("stalled result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ok_reg |-> out_reply_reg == '0)
        else $error("reply not cleared on failed check");
    assert property (@(posedge aclk) disable iff (!aresetn) !adv |-> !pop)
        else $error("pop while pipeline stalled");

endmodule
`default_nettype wire

>>> sv/aes128_challenge_verify_reply.sv
// top level: aes-128 challenge verify and reply, stream in, stream out
// results pass the queue, whitening register, round registers and output register
// one transaction per cycle unless stalled, set by the fully unrolled round pipeline
// a four-entry queue decouples input acceptance from output back-pressure
// reset and every key write run a key expansion, s_tready is low meanwhile
`default_nettype none
module aes128_challenge_verify_reply #(
    parameter int QUEUE_DEPTH = acv_pkg::Q_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // response_high, response_low, peer_chal_high, peer_chal_low,
    // expected_high, expected_low
    input  wire logic [383:0]                    s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // reply_high, reply_low
    output logic [127:0]                         m_tdata,
    // auth_ok
    output logic [0:0]                           m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [acv_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [acv_pkg::HALF_W-1:0]      cfg_wdata
);
    import acv_pkg::*;

    logic         key_busy;
    rk_set_t      round_keys;
    item_t        in_item;
    item_t        head_item;
    q_stat_t      q_stat;
    logic         push;
    logic         pop;
    logic         out_ok;
    logic [BLK_W-1:0] out_reply;

    acv_key_sched u_key (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .busy       (key_busy),
        .round_keys (round_keys)
    );

    // front: unpack halves into blocks, byte 0 on top of the high half
    assign in_item.resp       = {s_tdata[63:0],    s_tdata[127:64]};
    assign in_item.chal       = {s_tdata[191:128], s_tdata[255:192]};
    assign in_item.expect_blk = {s_tdata[319:256], s_tdata[383:320]};

    assign s_tready = !key_busy && !q_stat.full;
    assign push     = s_tvalid && s_tready;

    acv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (in_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    acv_round_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head_item  (head_item),
        .round_keys (round_keys),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ok     (out_ok),
        .out_reply  (out_reply)
    );

    // back: repack the reply halves
    assign m_tdata    = {out_reply[63:0], out_reply[127:64]};
    assign m_tuser[0] = out_ok;

    assert property (@(posedge aclk) disable iff (!aresetn) cfg_wr_en |=> !s_tready)
        else $error("input taken during key expansion");
    assert property (@(posedge aclk) disable iff (!aresetn) key_busy |-> !push)
        else $error("transaction accepted with stale round keys");
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid && m_tuser[0] == 1'b0
        |-> m_tdata == '0)
        else $error("nonzero reply on failed check");

endmodule
`default_nettype wire
